[src/ajb_pkg.sv]
// ----------------------------------------------------------------------------
// ajb_pkg
// Shared types, codes and reset constants of the adaptive jitter buffer control.
// ----------------------------------------------------------------------------
package ajb_pkg;

  localparam int unsigned CapacityDef   = 96;

  localparam logic [6:0]  FrameMsRst    = 7'd20;
  localparam logic [10:0] TargetMinRst  = 11'd60;
  localparam logic [11:0] TargetMaxRst  = 12'd200;
  localparam logic [3:0]  MaxConcealRst = 4'd8;

  typedef enum logic [1:0] {
    ACT_ARRIVE = 2'd0,
    ACT_PLAY   = 2'd1,
    ACT_FLUSH  = 2'd2
  } ajb_action_e;

  typedef enum logic [3:0] {
    OC_STORED   = 4'd0,
    OC_LATE     = 4'd1,
    OC_EVICT    = 4'd2,
    OC_PRIMING  = 4'd3,
    OC_PLAY     = 4'd4,
    OC_SILENCE  = 4'd5,
    OC_CONCEAL  = 4'd6,
    OC_NO_FRAME = 4'd7,
    OC_FLUSHED  = 4'd8
  } ajb_outcome_e;

  typedef enum logic [1:0] {
    REG_FRAME_MS    = 2'd0,
    REG_TARGET_MIN  = 2'd1,
    REG_TARGET_MAX  = 2'd2,
    REG_MAX_CONCEAL = 2'd3
  } ajb_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } ajb_state_e;

  typedef enum logic [1:0] {
    EST_IDLE,
    EST_DIFF,
    EST_JIT,
    EST_TGT
  } ajb_est_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] seq_num;
    logic [31:0] payload_handle;
    logic        is_silence;
    logic [47:0] arrival_ms;
  } ajb_in_t;

  typedef struct packed {
    logic [3:0]  outcome;
    logic [31:0] play_handle;
    logic [11:0] target_delay_ms;
    logic [15:0] jitter_ms;
    logic [6:0]  queued_count;
  } ajb_out_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] handle;
    logic        quiet;
  } ajb_slot_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic any;
    logic free_ok;
  } ajb_srch_t;

endpackage

[src/ajb_store.sv]
// ----------------------------------------------------------------------------
// ajb_store
// Packet slot memory with per-slot valid bits and a sweeping search unit.
// ----------------------------------------------------------------------------
module ajb_store #(
  parameter int unsigned CAPACITY = ajb_pkg::CapacityDef,
  parameter int unsigned IW       = $clog2(CAPACITY)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        key_i,
  input  logic               wr_en_i,
  input  logic [IW-1:0]      wr_idx_i,
  input  ajb_pkg::ajb_slot_t wr_slot_i,
  input  logic               clr_en_i,
  input  logic [IW-1:0]      clr_idx_i,
  input  logic               flush_i,
  output ajb_pkg::ajb_srch_t srch_o,
  output logic [IW-1:0]      hit_idx_o,
  output ajb_pkg::ajb_slot_t hit_slot_o,
  output logic [IW-1:0]      low_idx_o,
  output ajb_pkg::ajb_slot_t low_slot_o,
  output logic [IW-1:0]      free_idx_o
);
  import ajb_pkg::*;

  localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);

  ajb_slot_t mem [CAPACITY];
  ajb_slot_t rdata_q;

  logic [CAPACITY-1:0] valid_q;
  logic                sweep_q, pv_q;
  logic [IW-1:0]       rd_idx_q, pidx_q;
  logic [31:0]         key_q;
  ajb_srch_t           srch_q;
  logic [IW-1:0]       hit_idx_q, low_idx_q, free_idx_q;
  ajb_slot_t           hit_slot_q, low_slot_q;
  logic                cur_valid;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_slot_i;
    end
    rdata_q <= mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (flush_i) begin
      valid_q <= '0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (clr_en_i) begin
        valid_q[clr_idx_i] <= 1'b0;
      end
    end
  end

  assign cur_valid = valid_q[pidx_q];

  // Issue one read per cycle and evaluate it in the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q  <= 1'b0;
      pv_q     <= 1'b0;
      rd_idx_q <= '0;
      pidx_q   <= '0;
      srch_q   <= '0;
    end else if (start_i) begin
      sweep_q  <= 1'b1;
      pv_q     <= 1'b0;
      rd_idx_q <= '0;
      srch_q   <= '0;
    end else begin
      pv_q   <= sweep_q;
      pidx_q <= rd_idx_q;
      if (sweep_q) begin
        if (rd_idx_q == LastIdx) begin
          sweep_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
      if (pv_q) begin
        if (cur_valid && rdata_q.seq == key_q) begin
          srch_q.hit <= 1'b1;
        end
        if (cur_valid) begin
          srch_q.any <= 1'b1;
        end
        if (!cur_valid) begin
          srch_q.free_ok <= 1'b1;
        end
        if (pidx_q == LastIdx) begin
          srch_q.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    if (pv_q && !start_i) begin
      if (cur_valid && rdata_q.seq == key_q) begin
        hit_idx_q  <= pidx_q;
        hit_slot_q <= rdata_q;
      end
      if (cur_valid && (!srch_q.any || rdata_q.seq < low_slot_q.seq)) begin
        low_idx_q  <= pidx_q;
        low_slot_q <= rdata_q;
      end
      if (!cur_valid && !srch_q.free_ok) begin
        free_idx_q <= pidx_q;
      end
    end
  end

  assign srch_o     = srch_q;
  assign hit_idx_o  = hit_idx_q;
  assign hit_slot_o = hit_slot_q;
  assign low_idx_o  = low_idx_q;
  assign low_slot_o = low_slot_q;
  assign free_idx_o = free_idx_q;

endmodule

[src/ajb_estimator.sv]
// ----------------------------------------------------------------------------
// ajb_estimator
// Inter-arrival jitter smoothing and adaptive target delay, three steps in all.
// ----------------------------------------------------------------------------
module ajb_estimator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] now_i,
  input  logic [6:0]  frame_i,
  input  logic [10:0] tmin_i,
  input  logic [11:0] tmax_i,
  output logic        busy_o,
  output logic [15:0] jitter_o,
  output logic [11:0] target_o
);
  import ajb_pkg::*;

  ajb_est_e    phase_q, phase_d;
  logic [47:0] last_q;
  logic        seen_q;
  logic [48:0] x_q;
  logic [15:0] jit_q;
  logic [11:0] tgt_q;

  logic [47:0] diff;
  logic [47:0] dev;
  logic [48:0] jsum;
  logic [17:0] hi_raw;
  logic [11:0] hi, wanted;
  logic [16:0] blend;

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      EST_IDLE: if (start_i) phase_d = EST_DIFF;
      EST_DIFF: phase_d = seen_q ? EST_JIT : EST_IDLE;
      EST_JIT:  phase_d = EST_TGT;
      EST_TGT:  phase_d = EST_IDLE;
      default:  phase_d = EST_IDLE;
    endcase
  end

  always_comb begin
    diff   = now_i - last_q;
    dev    = x_q[48] ? 48'(-x_q) : x_q[47:0];
    jsum   = 49'({jit_q, 3'b000} - {3'b000, jit_q}) + {1'b0, dev};
    hi_raw = 18'(tmin_i) + 18'({jit_q, 1'b0});
    hi     = (hi_raw > 18'(tmax_i)) ? tmax_i : hi_raw[11:0];
    wanted = (hi < 12'(tmin_i)) ? 12'(tmin_i) : hi;
    blend  = 17'({tgt_q, 4'b0000}) - 17'(tgt_q) + 17'(wanted);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= EST_IDLE;
      last_q  <= '0;
      seen_q  <= 1'b0;
      jit_q   <= '0;
      tgt_q   <= 12'(TargetMinRst);
    end else begin
      phase_q <= phase_d;
      unique case (phase_q)
        EST_DIFF: begin
          last_q <= now_i;
          seen_q <= 1'b1;
        end
        EST_JIT: begin
          jit_q <= (jsum[48:19] != '0) ? 16'hFFFF : jsum[18:3];
        end
        EST_TGT: begin
          tgt_q <= (wanted > tgt_q) ? wanted : blend[15:4];
        end
        default: ;
      endcase
    end
  end

  // Signed interval minus one frame.
  always_ff @(posedge clk_i) begin
    if (phase_q == EST_DIFF) begin
      x_q <= {diff[47], diff} - {42'b0, frame_i};
    end
  end

  assign busy_o   = (phase_q != EST_IDLE);
  assign jitter_o = jit_q;
  assign target_o = tgt_q;

endmodule

[src/adaptive_jitter_buffer_control.sv]
// ----------------------------------------------------------------------------
// adaptive_jitter_buffer_control
// Playout control of an adaptive jitter buffer over a keyed packet store.
// ----------------------------------------------------------------------------
// Usage: one request on in_* is a packet arrival, a playout frame request or
// a flush; each produces exactly one result on out_*. Both channels use
// valid/ready. Configuration goes through cfg_* (index, data) and is always
// ready; write it only while the block is idle.
// Flow: arrivals and playout requests show their result after the sweep that
// reads every slot of the packet memory once through its single read port;
// flushes and unknown actions need no sweep. The next request is accepted in
// the cycle after a result is committed. One request is in flight at a time.
// Reset: the store is empty, the playout point unset, jitter zero and the
// target at its reset minimum; registers take their reset values.
// Stall: the result is held in an output register; the next request is
// accepted while it waits, but finishes only when the register frees up.
// ----------------------------------------------------------------------------
module adaptive_jitter_buffer_control #(
  parameter int unsigned CAPACITY = ajb_pkg::CapacityDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ajb_pkg::ajb_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ajb_pkg::ajb_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [11:0]      cfg_data_i
);
  import ajb_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = CW + 12;

  ajb_state_e  state_q, state_d;
  ajb_in_t     item_q;
  ajb_out_t    out_q;
  logic        out_valid_q;

  logic [6:0]  frame_q;
  logic [10:0] tmin_q;
  logic [11:0] tmax_q;
  logic [3:0]  maxc_q;

  logic [CW-1:0] held_q, held_d;
  logic [31:0]   pseq_q, pseq_d;
  logic          primed_q, primed_d;
  logic [3:0]    loss_q, loss_d;

  // Store interface.
  logic          in_acc, sweep_start, est_start, est_busy, commit;
  logic [31:0]   sweep_key;
  ajb_srch_t     srch;
  logic [IW-1:0] hit_idx, low_idx, free_idx;
  ajb_slot_t     hit_slot, low_slot, wr_slot;
  logic          wr_en, clr_en, flush;
  logic [IW-1:0] wr_idx, clr_idx;
  logic [15:0]   jitter;
  logic [11:0]   target;

  // Commit datapath.
  ajb_outcome_e  oc;
  logic [31:0]   play;
  logic [31:0]   pseq_arr, eff_seq;
  logic          use_low, eff_hit;
  logic [IW-1:0] eff_idx;
  ajb_slot_t     eff_slot;
  logic [PW-1:0] fill_ms;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign commit      = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // Arrivals search for their own number, requests for the playout point.
  assign sweep_start = in_acc && (in_data_i.action == ACT_ARRIVE ||
                                  in_data_i.action == ACT_PLAY);
  assign est_start   = in_acc && (in_data_i.action == ACT_ARRIVE);
  assign sweep_key   = (in_data_i.action == ACT_ARRIVE) ? in_data_i.seq_num : pseq_q;

  ajb_store #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sweep_start),
    .key_i      (sweep_key),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_slot_i  (wr_slot),
    .clr_en_i   (clr_en),
    .clr_idx_i  (clr_idx),
    .flush_i    (flush),
    .srch_o     (srch),
    .hit_idx_o  (hit_idx),
    .hit_slot_o (hit_slot),
    .low_idx_o  (low_idx),
    .low_slot_o (low_slot),
    .free_idx_o (free_idx)
  );

  ajb_estimator u_est (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (est_start),
    .now_i    (item_q.arrival_ms),
    .frame_i  (frame_q),
    .tmin_i   (tmin_q),
    .tmax_i   (tmax_q),
    .busy_o   (est_busy),
    .jitter_o (jitter),
    .target_o (target)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = sweep_start ? ST_SWEEP : ST_FINISH;
        end
      end
      ST_SWEEP: begin
        if (srch.done && !est_busy) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Decide the outcome and the state updates from the finished sweep.
  always_comb begin
    held_d   = held_q;
    pseq_d   = pseq_q;
    primed_d = primed_q;
    loss_d   = loss_q;
    oc       = OC_NO_FRAME;
    play     = '0;
    wr_en    = 1'b0;
    wr_idx   = hit_idx;
    clr_en   = 1'b0;
    clr_idx  = hit_idx;
    flush    = 1'b0;
    wr_slot.seq    = item_q.seq_num;
    wr_slot.handle = item_q.is_silence ? 32'd0 : item_q.payload_handle;
    wr_slot.quiet  = item_q.is_silence;

    pseq_arr = (pseq_q == '0) ? item_q.seq_num : pseq_q;
    // Priming that completes with an unset point plays from the lowest slot.
    use_low  = !primed_q && (held_q != '0) && (pseq_q == '0);
    eff_hit  = use_low ? srch.any : srch.hit;
    eff_idx  = use_low ? low_idx : hit_idx;
    eff_slot = use_low ? low_slot : hit_slot;
    eff_seq  = use_low ? low_slot.seq : pseq_q;
    fill_ms  = PW'(held_q) * PW'(frame_q);

    case (item_q.action)
      ACT_ARRIVE: begin
        pseq_d = pseq_arr;
        if (item_q.seq_num < pseq_arr) begin
          oc = OC_LATE;
        end else if (srch.hit) begin
          oc    = OC_STORED;
          wr_en = 1'b1;
        end else if (held_q < CW'(CAPACITY)) begin
          oc     = OC_STORED;
          wr_en  = srch.free_ok;
          wr_idx = free_idx;
          held_d = held_q + 1'b1;
        end else begin
          // Full: evict the lowest number unless the newcomer is lower still.
          oc     = OC_EVICT;
          wr_en  = srch.any && !(item_q.seq_num < low_slot.seq);
          wr_idx = low_idx;
        end
      end
      ACT_PLAY: begin
        if (!primed_q && fill_ms < PW'(target)) begin
          oc = OC_PRIMING;
        end else begin
          primed_d = 1'b1;
          if (eff_hit) begin
            clr_en  = 1'b1;
            clr_idx = eff_idx;
            held_d  = held_q - 1'b1;
            pseq_d  = eff_seq + 32'd1;
            loss_d  = '0;
            if (eff_slot.quiet) begin
              oc = OC_SILENCE;
            end else begin
              oc   = OC_PLAY;
              play = eff_slot.handle;
            end
          end else if (held_q != '0 && loss_q < maxc_q) begin
            pseq_d = eff_seq + 32'd1;
            loss_d = loss_q + 1'b1;
            oc     = OC_CONCEAL;
          end else if (held_q == '0) begin
            primed_d = 1'b0;
            loss_d   = '0;
            pseq_d   = '0;
          end
        end
      end
      ACT_FLUSH: begin
        flush    = 1'b1;
        held_d   = '0;
        pseq_d   = '0;
        primed_d = 1'b0;
        loss_d   = '0;
        oc       = OC_FLUSHED;
      end
      default: oc = OC_NO_FRAME;
    endcase

    // Hold the store unless the result is actually committed.
    if (!commit) begin
      wr_en  = 1'b0;
      clr_en = 1'b0;
      flush  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      held_q      <= '0;
      pseq_q      <= '0;
      primed_q    <= 1'b0;
      loss_q      <= '0;
      frame_q     <= FrameMsRst;
      tmin_q      <= TargetMinRst;
      tmax_q      <= TargetMaxRst;
      maxc_q      <= MaxConcealRst;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (ajb_reg_e'(cfg_index_i))
          REG_FRAME_MS:    frame_q <= cfg_data_i[6:0];
          REG_TARGET_MIN:  tmin_q  <= cfg_data_i[10:0];
          REG_TARGET_MAX:  tmax_q  <= cfg_data_i;
          REG_MAX_CONCEAL: maxc_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        held_q      <= held_d;
        pseq_q      <= pseq_d;
        primed_q    <= primed_d;
        loss_q      <= loss_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    if (commit) begin
      out_q.outcome         <= oc;
      out_q.play_handle     <= play;
      out_q.target_delay_ms <= target;
      out_q.jitter_ms       <= jitter;
      out_q.queued_count    <= 7'(held_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(CAPACITY))
    else $error("held count above capacity");

  a_play_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (oc == OC_PLAY || oc == OC_SILENCE) |=> held_q == $past(held_q) - 1'b1)
    else $error("played slot not removed from count");

  a_finish_est_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |-> !est_busy)
    else $error("result committed before estimate settled");
`endif

endmodule

[sim/tb_adaptive_jitter_buffer_control.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adaptive_jitter_buffer_control
// Self-checking bench: random and directed arrivals, playout frames and
// flushes against a behavioral predictor of the buffer, over several register
// settings, with random idling on both channels and back-pressure phases.
// ----------------------------------------------------------------------------
module tb_adaptive_jitter_buffer_control;
  import ajb_pkg::*;

  localparam int unsigned Cap      = CapacityDef;
  localparam int unsigned IdleLim  = 20000;
  localparam int unsigned DrainGap = 2 * Cap + 20;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ajb_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ajb_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  // Idle controls: percentage of idle cycles and a hold-off counter for the sink.
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned snk_hold;
  int unsigned quiet_cycles;
  bit          timed_out;

  adaptive_jitter_buffer_control uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor of the buffer plus the queue of predicted results.
  // --------------------------------------------------------------------------
  class jitter_buffer_board;
    logic [31:0] s_seq    [Cap];
    logic [31:0] s_handle [Cap];
    bit          s_quiet  [Cap];
    bit          s_valid  [Cap];
    int unsigned held;
    logic [31:0] play_pt;
    bit          primed;
    int unsigned loss;
    logic [47:0] last_t;
    bit          seen;
    int unsigned jit;
    int unsigned tgt;
    int unsigned frame_ms, tmin, tmax, conceal_max;
    ajb_out_t    pending[$];
    int unsigned errors;

    function new();
      frame_ms = FrameMsRst; tmin = TargetMinRst; tmax = TargetMaxRst;
      conceal_max = MaxConcealRst;
      foreach (s_valid[i]) s_valid[i] = 0;
      held = 0; play_pt = 0; primed = 0; loss = 0; last_t = 0; seen = 0;
      jit = 0; tgt = tmin; errors = 0;
    endfunction

    function void write_reg(ajb_reg_e idx, logic [11:0] val);
      case (idx)
        REG_FRAME_MS:    frame_ms = val[6:0];
        REG_TARGET_MIN:  tmin = val[10:0];
        REG_TARGET_MAX:  tmax = val;
        REG_MAX_CONCEAL: conceal_max = val[3:0];
        default: ;
      endcase
    endfunction

    function int lookup(logic [31:0] s);
      for (int i = 0; i < Cap; i++) if (s_valid[i] && s_seq[i] == s) return i;
      return -1;
    endfunction

    function int lowest();
      int b;
      b = -1;
      for (int i = 0; i < Cap; i++)
        if (s_valid[i] && (b < 0 || s_seq[i] < s_seq[b])) b = i;
      return b;
    endfunction

    function void estimate(logic [47:0] t);
      logic [47:0]     d;
      longint          x;
      longint unsigned j;
      int unsigned     hi, wanted;
      if (seen) begin
        d = t - last_t;
        x = longint'($signed(d)) - longint'(frame_ms);
        if (x < 0) x = -x;
        j = (longint'(jit) * 7 + x) / 8;
        jit = (j > 65535) ? 65535 : int'(j);
        hi = tmin + 2 * jit;
        if (hi > tmax) hi = tmax;
        wanted = (hi < tmin) ? tmin : hi;
        tgt = (wanted > tgt) ? wanted : (tgt * 15 + wanted) / 16;
      end
      last_t = t;
      seen = 1;
    endfunction

    function ajb_outcome_e store(logic [31:0] s, logic [31:0] h, bit q);
      int i;
      ajb_outcome_e r;
      r = OC_STORED;
      i = lookup(s);
      if (i < 0) begin
        if (held < Cap) begin
          for (int k = Cap - 1; k >= 0; k--) if (!s_valid[k]) i = k;
          held++;
        end else begin
          i = lowest();
          r = OC_EVICT;
          if (s < s_seq[i]) return r;
        end
      end
      s_seq[i] = s; s_handle[i] = q ? '0 : h; s_quiet[i] = q; s_valid[i] = 1;
      return r;
    endfunction

    function ajb_outcome_e frame(output logic [31:0] h);
      int i;
      h = '0;
      if (!primed) begin
        if (held * frame_ms < tgt) return OC_PRIMING;
        primed = 1;
        if (held > 0 && play_pt == 0) play_pt = s_seq[lowest()];
      end
      i = lookup(play_pt);
      if (i >= 0) begin
        s_valid[i] = 0; held--; play_pt++; loss = 0;
        if (s_quiet[i]) return OC_SILENCE;
        h = s_handle[i];
        return OC_PLAY;
      end
      if (held > 0 && loss < conceal_max) begin
        play_pt++; loss++;
        return OC_CONCEAL;
      end
      if (held == 0) begin
        primed = 0; loss = 0; play_pt = 0;
      end
      return OC_NO_FRAME;
    endfunction

    // Note an accepted request and queue its predicted result.
    function void note_request(ajb_in_t r);
      ajb_out_t e;
      logic [31:0] h;
      h = '0;
      case (r.action)
        ACT_ARRIVE: begin
          estimate(r.arrival_ms);
          if (play_pt == 0) play_pt = r.seq_num;
          if (r.seq_num < play_pt) e.outcome = OC_LATE;
          else e.outcome = store(r.seq_num, r.payload_handle, r.is_silence);
        end
        ACT_PLAY: e.outcome = frame(h);
        ACT_FLUSH: begin
          foreach (s_valid[i]) s_valid[i] = 0;
          held = 0; play_pt = 0; primed = 0; loss = 0;
          e.outcome = OC_FLUSHED;
        end
        default: e.outcome = OC_NO_FRAME;
      endcase
      e.play_handle = h;
      e.target_delay_ms = tgt[11:0];
      e.jitter_ms = jit[15:0];
      e.queued_count = held[6:0];
      pending.push_back(e);
    endfunction

    // Compare one result against the oldest prediction.
    function void check_result(ajb_out_t a);
      ajb_out_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", a);
        return;
      end
      e = pending.pop_front();
      if (a.outcome !== e.outcome || a.play_handle !== e.play_handle ||
          a.target_delay_ms !== e.target_delay_ms || a.jitter_ms !== e.jitter_ms ||
          a.queued_count !== e.queued_count) begin
        errors++;
        if (errors <= 10) $display("mismatch exp %p act %p", e, a);
      end
    endfunction
  endclass

  jitter_buffer_board board;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sink: random stalls, plus a forced hold-off window counted here.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) board.check_result(out_data);
      if (snk_hold > 0) begin
        snk_hold <= snk_hold - 1;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog: count cycles with no accepted request or result and no sink hold-off.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || snk_hold > 0)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IdleLim && !timed_out) begin
      timed_out = 1;
      $display("** adaptive_jitter_buffer_control: FAILED **");
      $finish;
    end
  end

  // Offer one request; valid stays up afterwards until the next idle cycle.
  task automatic send(ajb_in_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(r);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DrainGap) @(posedge clk);
  endtask

  task automatic write_cfg(ajb_reg_e idx, logic [11:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic ajb_in_t mk(ajb_action_e a, logic [31:0] s, logic [31:0] h,
                                 bit q, logic [47:0] t);
    ajb_in_t r;
    r.action = a; r.seq_num = s; r.payload_handle = h; r.is_silence = q;
    r.arrival_ms = t;
    return r;
  endfunction

  // Random phase: mostly well-formed streams of sequential packets with
  // interleaved playout, plus reorder, loss, duplicates and noise.
  task automatic stream(int unsigned n, int unsigned seq_span);
    logic [31:0] s;
    logic [47:0] t;
    int unsigned k;
    s = $urandom_range(seq_span) + 1;
    t = 48'({$urandom, $urandom});
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      t = t + $urandom_range(40);
      if (k < 3) t = 48'({$urandom, $urandom});
      if (k < 45) begin
        send(mk(ACT_ARRIVE, s + $urandom_range(3), $urandom, $urandom_range(9) == 0, t));
        s = s + ($urandom_range(3) == 0 ? 2 : 1);
      end else if (k < 50) begin
        send(mk(ACT_ARRIVE, {$urandom}, $urandom, 1'($urandom_range(1)), t));
      end else if (k < 52) begin
        send(mk(ACT_FLUSH, $urandom, $urandom, 1'($urandom_range(1)),
                48'({$urandom, $urandom})));
      end else if (k < 53) begin
        send(mk(ajb_action_e'(2'd3), $urandom, $urandom, 1'($urandom_range(1)), t));
      end else begin
        send(mk(ACT_PLAY, $urandom, $urandom, 1'($urandom_range(1)),
                48'({$urandom, $urandom})));
      end
    end
  endtask

  initial begin
    ajb_in_t fill;
    board = new();
    rst_n = 0; in_valid = 0; in_data = '0; cfg_valid = 0; cfg_index = REG_FRAME_MS;
    cfg_data = '0; src_idle_pct = 38; snk_idle_pct = 38; snk_hold = 0;
    quiet_cycles = 0; timed_out = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: priming, play, silence, conceal, late, duplicate, wraps, flush.
    send(mk(ACT_PLAY, 0, 0, 0, 0));
    send(mk(ACT_ARRIVE, 10, 32'hFFFF_FFFF, 0, 48'd100));
    send(mk(ACT_ARRIVE, 11, 32'h1234_5678, 1, 48'd120));
    send(mk(ACT_ARRIVE, 11, 32'hA5A5_A5A5, 0, 48'd90));
    send(mk(ACT_ARRIVE, 13, 32'h0F0F_0F0F, 0, 48'hFFFF_FFFF_FFFF));
    send(mk(ACT_ARRIVE, 3, 32'h5555_5555, 0, 48'h8000_0000_0000));
    send(mk(ACT_ARRIVE, 14, 32'hAAAA_AAAA, 1, 48'h0));
    for (int i = 0; i < 6; i++) send(mk(ACT_PLAY, 0, 0, 0, 0));
    send(mk(ACT_ARRIVE, 32'hFFFF_FFFF, 32'h1, 0, 48'h10));
    send(mk(ACT_ARRIVE, 32'hFFFF_FFFE, 32'h2, 0, 48'h20));
    send(mk(ACT_ARRIVE, 32'h0, 32'h3, 0, 48'h30));
    for (int i = 0; i < 4; i++) send(mk(ACT_PLAY, 0, 0, 0, 0));
    send(mk(ajb_action_e'(2'd3), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '1));
    send(mk(ACT_FLUSH, '1, '1, 1, '1));
    wait_drained();

    // Settings sweep: extremes, inverted clamp, zero conceal.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_cfg(REG_FRAME_MS, 12'd1); write_cfg(REG_TARGET_MIN, 12'd0);
          write_cfg(REG_TARGET_MAX, 12'd4000); write_cfg(REG_MAX_CONCEAL, 12'd0);
        end
        1: begin
          write_cfg(REG_FRAME_MS, 12'd120); write_cfg(REG_TARGET_MIN, 12'd2000);
          write_cfg(REG_TARGET_MAX, 12'd0); write_cfg(REG_MAX_CONCEAL, 12'd15);
        end
        2: begin
          write_cfg(REG_FRAME_MS, 12'd20); write_cfg(REG_TARGET_MIN, 12'd60);
          write_cfg(REG_TARGET_MAX, 12'd200); write_cfg(REG_MAX_CONCEAL, 12'd8);
        end
        default: begin
          write_cfg(REG_FRAME_MS, 12'($urandom_range(120, 1)));
          write_cfg(REG_TARGET_MIN, 12'($urandom_range(2047)));
          write_cfg(REG_TARGET_MAX, 12'($urandom_range(4095)));
          write_cfg(REG_MAX_CONCEAL, 12'($urandom_range(15)));
        end
      endcase
      src_idle_pct = (phase == 3) ? 0 : 38;
      snk_idle_pct = (phase == 3) ? 0 : 38;
      stream(250, (phase == 4) ? 32'hFFFF_FF00 : 1000);
      wait_drained();
    end

    // Send more arrivals than the capacity holds, with the sink held off
    // meanwhile so the block backs up and stalls its input.
    write_cfg(REG_TARGET_MIN, 12'd2000);
    snk_hold = 600;
    for (int i = 0; i < 110; i++) begin
      fill = mk(ACT_ARRIVE, 1000 + $urandom_range(150), $urandom,
                1'($urandom_range(1)), 48'd20 * i);
      send(fill);
    end
    send(mk(ACT_ARRIVE, 5, 32'h77, 0, 48'd5000));
    for (int i = 0; i < 20; i++) send(mk(ACT_PLAY, 0, 0, 0, 0));
    wait_drained();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("** adaptive_jitter_buffer_control: PASSED **");
    end else begin
      $display("** adaptive_jitter_buffer_control: FAILED **");
    end
    $finish;
  end
endmodule
